/* hw/rtl/cbz_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cbz_pkg
// Shared types and constants of the cubic Bezier segment generator: the
// axis datapath operation codes and the controller/datapath command and
// status bundles.
// ---------------------------------------------------------------------------
package cbz_pkg;

    // fixed field and register widths
    localparam int OUT_BITS  = 20;   // output coordinate width
    localparam int SEG_BITS  = 6;    // segment_count register width
    localparam int T_FRAC    = 16;   // fraction bits of the curve parameter t
    localparam int T_BITS    = 17;   // t with one integer bit, t = 1 included
    localparam int LO_BITS   = 24;   // split point of the last horner product
    localparam int APB_AW    = 3;    // byte address bits of the config port
    localparam int APB_DW    = 32;   // config data width

    // register map, indexed by word address paddr[2]
    localparam logic REG_SEG_COUNT = 1'b0;
    localparam logic [SEG_BITS-1:0] SEG_COUNT_RESET = 6'd50;

    // operations of one axis evaluator
    typedef enum logic [3:0] {
        AX_HOLD,
        AX_LOAD,
        AX_MUL_A3,
        AX_ADD_A2,
        AX_MUL_ACC,
        AX_ADD_A1,
        AX_MUL_LO,
        AX_MUL_HI,
        AX_ADD_FIN,
        AX_ROUND
    } t_axis_op;

    // controller to datapath
    typedef struct packed {
        logic     load;   // capture a new curve and start the t step division
        t_axis_op op;     // operation for both axis lanes
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic seg_zero;   // configured segment count is zero
        logic div_done;   // step size division finished
        logic end_point;  // current point is the trailing end point
    } t_dp_status;

endpackage
`default_nettype wire

/* hw/rtl/cubic_bezier_segment_generator.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cubic_bezier_segment_generator
// Evaluates a cubic Bezier curve at n+2 points (start, t = k/n for k = 1..n,
// end again) with exact integer arithmetic and one rounding per coordinate.
// ---------------------------------------------------------------------------
// A curve is taken when start is high and busy is low; a segment count of
// zero does not take the curve and emits nothing. After the taking edge busy
// stays high through the step size division 2^16/n, the hand-over to the
// point loop and the horner sequence of every point on the one multiplier
// of each axis lane. The next curve can be taken at the end of the first
// cycle with busy low. Each point appears for a single cycle with o_strobe
// high and the receiver cannot hold it off; the final point of a run has
// o_last set. Busy falls in the cycle the last point is shown.
// segment_count (offset 0, reset 50) is sampled when a curve is taken.
// ---------------------------------------------------------------------------
module cubic_bezier_segment_generator #(
    parameter int MAX_SEGMENTS = 62,
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // config port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire logic [cbz_pkg::APB_AW-1:0]       paddr,
    input  wire logic [cbz_pkg::APB_DW-1:0]       pwdata,
    output logic [cbz_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready,
    // curve input
    input  wire                                   start,
    output logic                                  busy,
    input  wire logic [COORD_BITS-1:0]            i_start_x,
    input  wire logic [COORD_BITS-1:0]            i_start_y,
    input  wire logic [COORD_BITS-1:0]            i_start_ctrl_x,
    input  wire logic [COORD_BITS-1:0]            i_start_ctrl_y,
    input  wire logic [COORD_BITS-1:0]            i_end_ctrl_x,
    input  wire logic [COORD_BITS-1:0]            i_end_ctrl_y,
    input  wire logic [COORD_BITS-1:0]            i_end_x,
    input  wire logic [COORD_BITS-1:0]            i_end_y,
    // curve points
    output logic                                  o_strobe,
    output logic signed [cbz_pkg::OUT_BITS-1:0]   o_curve_x,
    output logic signed [cbz_pkg::OUT_BITS-1:0]   o_curve_y,
    output logic                                  o_last
);
    import cbz_pkg::*;

    logic [SEG_BITS-1:0] r_seg_count;
    logic                cfg_wr;
    logic                ctrl_busy;
    t_dp_cmd             dp_cmd;
    t_dp_status          dp_status;

    // config register write
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SEG_COUNT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_SEG_COUNT)) begin
            r_seg_count <= pwdata[SEG_BITS-1:0];
        end
    end

    // config readback
    always_comb begin
        if (paddr[2] == REG_SEG_COUNT) begin
            prdata = APB_DW'(r_seg_count);
        end else begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    cbz_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (ctrl_busy)
    );

    cbz_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_seg_count    (r_seg_count),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_start_ctrl_x (i_start_ctrl_x),
        .i_start_ctrl_y (i_start_ctrl_y),
        .i_end_ctrl_x   (i_end_ctrl_x),
        .i_end_ctrl_y   (i_end_ctrl_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_status       (dp_status),
        .o_strobe       (o_strobe),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_last         (o_last)
    );

    assign busy = ctrl_busy;

endmodule
`default_nettype wire

/* hw/rtl/cbz_axis.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cbz_axis
// One coordinate axis: power basis coefficients of the cubic, exact horner
// evaluation at t on a shared signed multiplier, and rounding to the output
// fraction with saturation.
// ---------------------------------------------------------------------------
module cbz_axis #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  wire                                   i_clk,
    input  wire cbz_pkg::t_axis_op                i_op,
    input  wire logic signed [COORD_BITS-1:0]     i_p0,
    input  wire logic signed [COORD_BITS-1:0]     i_p1,
    input  wire logic signed [COORD_BITS-1:0]     i_p2,
    input  wire logic signed [COORD_BITS-1:0]     i_p3,
    input  wire logic [cbz_pkg::T_BITS-1:0]       i_t,
    output logic signed [cbz_pkg::OUT_BITS-1:0]   o_coord
);
    import cbz_pkg::*;

    localparam int CW  = COORD_BITS + 4;     // coefficient width
    localparam int MW  = COORD_BITS + 21;    // multiplier operand width
    localparam int H2W = COORD_BITS + 37;    // second horner partial
    localparam int PW  = MW + T_BITS + 1;    // product width
    localparam int AW  = COORD_BITS + 53;    // accumulator, scale 2^48
    localparam int SH  = 3 * T_FRAC - FRAC_BITS;
    localparam int RW  = AW - SH;
    localparam int EW  = (RW > OUT_BITS) ? RW : OUT_BITS + 1;
    localparam int LW  = LO_BITS + T_BITS;
    localparam logic signed [EW-1:0] SAT_HI = EW'((2 ** (OUT_BITS - 1)) - 1);
    localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

    logic signed [CW-1:0] p0e, p1e, p2e, p3e;
    logic signed [CW-1:0] d12, d10, s2;
    logic signed [CW-1:0] a0, a1, a2, a3;
    logic signed [CW-1:0] r_a0, r_a1, r_a2, r_a3;
    logic signed [MW-1:0] mul_a;
    logic signed [T_BITS:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] r_prod;
    logic [LW-1:0]        r_lo;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] prod_ext, a0_ext, a1_ext, a2_ext;
    logic [AW-1:0]        lo_ext;
    logic signed [AW-1:0] rsum;
    logic signed [EW-1:0] rq;
    logic signed [OUT_BITS-1:0] sat;
    logic signed [OUT_BITS-1:0] r_out;

    // power basis coefficients: a3 t^3 + a2 t^2 + a1 t + a0
    assign p0e = CW'(i_p0);
    assign p1e = CW'(i_p1);
    assign p2e = CW'(i_p2);
    assign p3e = CW'(i_p3);
    assign d12 = p1e - p2e;
    assign d10 = p1e - p0e;
    assign s2  = p0e - (p1e <<< 1) + p2e;
    assign a0  = p0e;
    assign a1  = d10 + (d10 <<< 1);
    assign a2  = s2 + (s2 <<< 1);
    assign a3  = p3e - p0e + d12 + (d12 <<< 1);

    // multiplier operand select
    always_comb begin
        case (i_op)
            AX_MUL_A3:  mul_a = MW'(r_a3);
            AX_MUL_ACC: mul_a = $signed(r_acc[MW-1:0]);
            AX_MUL_LO:  mul_a = $signed({{(MW - LO_BITS){1'b0}}, r_acc[LO_BITS-1:0]});
            AX_MUL_HI:  mul_a = MW'($signed(r_acc[H2W-1:LO_BITS]));
            default:    mul_a = '0;
        endcase
    end

    assign mul_b = $signed({1'b0, i_t});
    assign prod  = PW'(mul_a) * PW'(mul_b);

    // operands of the accumulating adds, extended to the accumulator width
    assign prod_ext = AW'(r_prod);
    assign a0_ext   = AW'(r_a0);
    assign a1_ext   = AW'(r_a1);
    assign a2_ext   = AW'(r_a2);
    assign lo_ext   = AW'(r_lo);

    // round to nearest, ties up, then saturate
    assign rsum = r_acc + (AW'(1) <<< (SH - 1));
    assign rq   = EW'($signed(rsum[AW-1:SH]));
    always_comb begin
        if (rq > SAT_HI) begin
            sat = SAT_HI[OUT_BITS-1:0];
        end else if (rq < SAT_LO) begin
            sat = SAT_LO[OUT_BITS-1:0];
        end else begin
            sat = rq[OUT_BITS-1:0];
        end
    end

    // horner sequence registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            AX_LOAD: begin
                r_a0 <= a0;
                r_a1 <= a1;
                r_a2 <= a2;
                r_a3 <= a3;
            end
            AX_MUL_A3, AX_MUL_ACC, AX_MUL_LO: begin
                r_prod <= prod;
            end
            AX_MUL_HI: begin
                r_lo   <= r_prod[LW-1:0];
                r_prod <= prod;
            end
            AX_ADD_A2: begin
                r_acc <= prod_ext + (a2_ext <<< T_FRAC);
            end
            AX_ADD_A1: begin
                r_acc <= prod_ext + (a1_ext <<< (2 * T_FRAC));
            end
            AX_ADD_FIN: begin
                r_acc <= (prod_ext <<< LO_BITS) + $signed(lo_ext) + (a0_ext <<< (3 * T_FRAC));
            end
            AX_ROUND: begin
                r_out <= sat;
            end
            default: begin
            end
        endcase
    end

    assign o_coord = r_out;

endmodule
`default_nettype wire

/* hw/rtl/cbz_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cbz_datapath
// Control point store, step size division 2^16 / n, exact t stepper for
// t = floor(k * 2^16 / n), two axis evaluators and the result register.
// ---------------------------------------------------------------------------
module cbz_datapath #(
    parameter int MAX_SEGMENTS = 62,
    parameter int COORD_BITS   = 12,
    parameter int FRAC_BITS    = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire cbz_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [cbz_pkg::SEG_BITS-1:0]     i_seg_count,
    input  wire logic [COORD_BITS-1:0]            i_start_x,
    input  wire logic [COORD_BITS-1:0]            i_start_y,
    input  wire logic [COORD_BITS-1:0]            i_start_ctrl_x,
    input  wire logic [COORD_BITS-1:0]            i_start_ctrl_y,
    input  wire logic [COORD_BITS-1:0]            i_end_ctrl_x,
    input  wire logic [COORD_BITS-1:0]            i_end_ctrl_y,
    input  wire logic [COORD_BITS-1:0]            i_end_x,
    input  wire logic [COORD_BITS-1:0]            i_end_y,
    output cbz_pkg::t_dp_status                   o_status,
    output logic                                  o_strobe,
    output logic signed [cbz_pkg::OUT_BITS-1:0]   o_curve_x,
    output logic signed [cbz_pkg::OUT_BITS-1:0]   o_curve_y,
    output logic                                  o_last
);
    import cbz_pkg::*;

    localparam int KW = $clog2(MAX_SEGMENTS + 2);
    localparam int CNT_W = $clog2(T_BITS);

    logic [COORD_BITS-1:0] r_pts [8];
    logic [KW-1:0]         r_n;
    logic [KW-1:0]         seg_sat;
    logic                  r_div_run;
    logic [CNT_W-1:0]      r_div_cnt;
    logic [KW-1:0]         r_rem;
    logic [T_BITS-1:0]     r_quo;
    logic [KW:0]           div_sh;
    logic                  div_ge;
    logic [T_BITS-1:0]     r_t;
    logic [KW-1:0]         r_r;
    logic [KW-1:0]         r_k;
    logic [KW:0]           step_rs;
    logic                  step_wrap;
    logic                  end_point;
    logic                  r_strobe;
    logic                  r_last;

    // saturate the segment count at the build limit
    assign seg_sat = (i_seg_count > SEG_BITS'(MAX_SEGMENTS)) ? KW'(MAX_SEGMENTS)
                                                            : KW'(i_seg_count);

    // capture the control points, x and y interleaved
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pts[0] <= i_start_x;
            r_pts[1] <= i_start_y;
            r_pts[2] <= i_start_ctrl_x;
            r_pts[3] <= i_start_ctrl_y;
            r_pts[4] <= i_end_ctrl_x;
            r_pts[5] <= i_end_ctrl_y;
            r_pts[6] <= i_end_x;
            r_pts[7] <= i_end_y;
            r_n      <= seg_sat;
        end
    end

    // restoring division of 2^16 by n, one quotient bit per cycle
    assign div_sh = {r_rem, (r_div_cnt == CNT_W'(T_FRAC))};
    assign div_ge = (div_sh >= {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
        end else if (i_cmd.load) begin
            r_div_run <= 1'b1;
        end else if (r_div_run && (r_div_cnt == '0)) begin
            r_div_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div_cnt <= CNT_W'(T_FRAC);
            r_rem     <= '0;
            r_quo     <= '0;
        end else if (r_div_run) begin
            r_div_cnt <= r_div_cnt - CNT_W'(1);
            r_rem     <= div_ge ? KW'(div_sh - {1'b0, r_n}) : KW'(div_sh);
            r_quo     <= {r_quo[T_BITS-2:0], div_ge};
        end
    end

    // t stepper: t advances by the quotient, the remainder carries an extra step
    assign step_rs   = {1'b0, r_r} + {1'b0, r_rem};
    assign step_wrap = (step_rs >= {1'b0, r_n});
    assign end_point = (r_k == r_n + KW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t <= '0;
            r_r <= '0;
            r_k <= '0;
        end else if ((i_cmd.op == AX_ROUND) && !end_point) begin
            r_k <= r_k + KW'(1);
            if (r_k < r_n) begin
                if (step_wrap) begin
                    r_t <= r_t + r_quo + T_BITS'(1);
                    r_r <= KW'(step_rs - {1'b0, r_n});
                end else begin
                    r_t <= r_t + r_quo;
                    r_r <= KW'(step_rs);
                end
            end
        end
    end

    // axis lanes
    cbz_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_op    (i_cmd.op),
        .i_p0    ($signed(r_pts[0])),
        .i_p1    ($signed(r_pts[2])),
        .i_p2    ($signed(r_pts[4])),
        .i_p3    ($signed(r_pts[6])),
        .i_t     (r_t),
        .o_coord (o_curve_x)
    );

    cbz_axis #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_op    (i_cmd.op),
        .i_p0    ($signed(r_pts[1])),
        .i_p1    ($signed(r_pts[3])),
        .i_p2    ($signed(r_pts[5])),
        .i_p3    ($signed(r_pts[7])),
        .i_t     (r_t),
        .o_coord (o_curve_y)
    );

    // result strobe and last flag, aligned with the rounded coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == AX_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == AX_ROUND) begin
            r_last <= end_point;
        end
    end

    assign o_strobe = r_strobe;
    assign o_last   = r_last;

    assign o_status.seg_zero  = (i_seg_count == '0);
    assign o_status.div_done  = !r_div_run;
    assign o_status.end_point = end_point;

endmodule
`default_nettype wire

/* hw/rtl/cbz_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cbz_ctrl
// Sequencer of the generator: accepts a curve, waits for the step size
// division, then walks the eight horner steps once per curve point.
// ---------------------------------------------------------------------------
module cbz_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire cbz_pkg::t_dp_status i_status,
    output cbz_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy
);
    import cbz_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MUL_A3,
        S_ADD_A2,
        S_MUL_ACC,
        S_ADD_A1,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD_FIN,
        S_ROUND
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   accept;

    // a zero segment count does not take the item and produces nothing
    assign accept = (r_state == S_IDLE) && i_start && !i_status.seg_zero;

    // next state
    always_comb begin
        case (r_state)
            S_IDLE:    n_state = accept ? S_DIV : S_IDLE;
            S_DIV:     n_state = i_status.div_done ? S_MUL_A3 : S_DIV;
            S_MUL_A3:  n_state = S_ADD_A2;
            S_ADD_A2:  n_state = S_MUL_ACC;
            S_MUL_ACC: n_state = S_ADD_A1;
            S_ADD_A1:  n_state = S_MUL_LO;
            S_MUL_LO:  n_state = S_MUL_HI;
            S_MUL_HI:  n_state = S_ADD_FIN;
            S_ADD_FIN: n_state = S_ROUND;
            S_ROUND:   n_state = i_status.end_point ? S_IDLE : S_MUL_A3;
            default:   n_state = S_IDLE;
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    // datapath command
    always_comb begin
        o_cmd.load = accept;
        case (r_state)
            S_DIV:     o_cmd.op = AX_LOAD;
            S_MUL_A3:  o_cmd.op = AX_MUL_A3;
            S_ADD_A2:  o_cmd.op = AX_ADD_A2;
            S_MUL_ACC: o_cmd.op = AX_MUL_ACC;
            S_ADD_A1:  o_cmd.op = AX_ADD_A1;
            S_MUL_LO:  o_cmd.op = AX_MUL_LO;
            S_MUL_HI:  o_cmd.op = AX_MUL_HI;
            S_ADD_FIN: o_cmd.op = AX_ADD_FIN;
            S_ROUND:   o_cmd.op = AX_ROUND;
            default:   o_cmd.op = AX_HOLD;
        endcase
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire
